### hw/rtl/lbfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbfc_pkg
// Shared types and constants of the line byte/field cutter: item layouts,
// register map codes, range selection flags and parameter defaults.
// ----------------------------------------------------------------------------
package lbfc_pkg;

	// Parameter defaults
	localparam int unsigned MAX_RANGES_DEF    = 4;
	localparam int unsigned HOLD_DEPTH_DEF    = 62;
	localparam int unsigned POSITION_BITS_DEF = 16;

	// Fixed widths
	localparam int unsigned SLOT_W     = 16;
	localparam int unsigned RANGE_W    = 64;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_ADDR_W = 6;

	localparam logic [7:0] NEWLINE     = 8'd10;
	localparam logic [7:0] DELIM_RESET = 8'd9;

	// Register map, eight bytes apart
	typedef enum logic [2:0] {
		REG_CUT_MODE     = 3'd0,
		REG_DELIMITER    = 3'd1,
		REG_SUPPRESS     = 3'd2,
		REG_RANGE_COUNT  = 3'd3,
		REG_RANGE_STARTS = 3'd4,
		REG_RANGE_ENDS   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} lbfc_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       held_overflow;
		logic       last_of_run;
	} lbfc_out_t;

	// Range match results for the current and the advanced position
	typedef struct packed {
		logic hit_cur;
		logic hit_next;
		logic next_above_min;
	} lbfc_sel_t;

endpackage
`default_nettype wire

### hw/rtl/lbfc_hold_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbfc_hold_mem
// Hold store for the first field of a line: one write port, one read port,
// registered read data.
// ----------------------------------------------------------------------------
module lbfc_hold_mem #(
	parameter int unsigned DEPTH = lbfc_pkg::HOLD_DEPTH_DEF,
	parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire logic [7:0]       wdata,
	input  wire logic             re,
	input  wire logic [IDX_W-1:0] raddr,
	output logic      [7:0]       rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Hold the read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### hw/rtl/lbfc_range_sel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbfc_range_sel
// Range matcher: tests the current and the advanced position against the
// valid range slots and compares the advanced position with the smallest start.
// ----------------------------------------------------------------------------
module lbfc_range_sel #(
	parameter int unsigned MAX_RANGES    = lbfc_pkg::MAX_RANGES_DEF,
	parameter int unsigned POSITION_BITS = lbfc_pkg::POSITION_BITS_DEF
) (
	input  wire logic [2:0]                     range_count,
	input  wire logic [lbfc_pkg::RANGE_W-1:0]   range_starts,
	input  wire logic [lbfc_pkg::RANGE_W-1:0]   range_ends,
	input  wire logic [POSITION_BITS-1:0]       pos_cur,
	input  wire logic [POSITION_BITS-1:0]       pos_next,
	output lbfc_pkg::lbfc_sel_t                 sel
);

	localparam int unsigned SW = lbfc_pkg::SLOT_W;

	always_comb begin
		logic [SW-1:0] s;
		logic [SW-1:0] e;
		logic [SW-1:0] pc;
		logic [SW-1:0] pn;
		logic [SW:0]   mn;
		logic          used;
		pc  = SW'(pos_cur);
		pn  = SW'(pos_next);
		mn  = '1;
		sel = '0;
		for (int k = 0; k < MAX_RANGES; k++) begin
			used = (3'(k) < range_count);
			s = range_starts[k*SW +: SW];
			e = range_ends[k*SW +: SW];
			// start zero acts as one
			if (s == '0) begin
				s = SW'(1);
			end
			if (used) begin
				if (pc >= s && (e == '0 || pc <= e)) begin
					sel.hit_cur = 1'b1;
				end
				if (pn >= s && (e == '0 || pn <= e)) begin
					sel.hit_next = 1'b1;
				end
				if ({1'b0, s} < mn) begin
					mn = {1'b0, s};
				end
			end
		end
		sel.next_above_min = ({1'b0, pn} > mn);
	end

endmodule
`default_nettype wire

### hw/rtl/line_byte_field_cutter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_byte_field_cutter_top
// Streaming cut of byte positions or delimited fields from newline-ended lines.
// ----------------------------------------------------------------------------
// Text enters one item (a byte or an end-of-stream mark) per cycle on the src
// channel while the block is idle, and selected bytes leave on the dst channel
// through a single output register, so a new item is taken whenever the block
// is idle and that register is empty or being drained. In field mode the
// first field of a line is parked in a hold memory with one write and one
// read port until a delimiter, newline or end of stream decides its fate;
// releasing it takes the item, then for each held byte a memory read and a
// load into the output register, then any trailing newline or delimiter, all
// stretched by dst_stall. The src channel is stalled throughout the release.
// The hold memory needs no clearing pass: only entries below the held count
// are read. Registers sit on an APB port, eight bytes apart, 64 bits wide;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module line_byte_field_cutter_top #(
	parameter int unsigned MAX_RANGES    = lbfc_pkg::MAX_RANGES_DEF,
	parameter int unsigned HOLD_DEPTH    = lbfc_pkg::HOLD_DEPTH_DEF,
	parameter int unsigned POSITION_BITS = lbfc_pkg::POSITION_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              src_valid,
	output logic                                   src_stall,
	input  wire lbfc_pkg::lbfc_in_t                src_item,
	output logic                                   dst_valid,
	input  wire logic                              dst_stall,
	output lbfc_pkg::lbfc_out_t                    dst_item,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lbfc_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [lbfc_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic      [lbfc_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                                   pready
);

	localparam int unsigned CNT_W = $clog2(HOLD_DEPTH + 1);
	localparam int unsigned IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int unsigned DW    = lbfc_pkg::CFG_DATA_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FL_RD,
		S_FL_EMIT,
		S_TAIL
	} state_t;

	// Configuration registers
	logic                           cut_mode_q;
	logic [7:0]                     delimiter_q;
	logic                           suppress_q;
	logic [2:0]                     range_count_q;
	logic [lbfc_pkg::RANGE_W-1:0]   range_starts_q;
	logic [lbfc_pkg::RANGE_W-1:0]   range_ends_q;

	// Line state
	logic [POSITION_BITS-1:0]       pos_q;
	logic                           dseen_q;
	logic [CNT_W-1:0]               hcnt_q;
	logic                           ovf_q;

	// Sequencer and output register
	state_t                         state_q;
	logic                           out_valid_q;
	lbfc_pkg::lbfc_out_t            out_q;
	logic [IDX_W-1:0]               idx_q;
	logic [IDX_W-1:0]               flush_last_q;
	logic                           tail_q;
	logic [7:0]                     tail_byte_q;
	logic                           flush_ovf_q;

	logic                           accept;
	logic                           slot_free;
	logic                           out_load;
	logic [POSITION_BITS-1:0]       pos_adv;
	logic [CNT_W-1:0]               hcnt_dec;
	lbfc_pkg::lbfc_sel_t            sel;
	logic [7:0]                     mem_rdata;
	logic                           mem_we;
	logic                           mem_re;
	logic                           cfg_wr;

	// Step decode
	logic                           emit_now;
	logic [7:0]                     emit_byte;
	logic                           start_flush;
	logic                           tail_flag;
	logic [7:0]                     tail_byte;
	logic                           clr_line;
	logic                           adv;
	logic                           set_dseen;
	logic                           clr_hcnt;
	logic                           set_ovf;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_mode_q     <= 1'b0;
			delimiter_q    <= lbfc_pkg::DELIM_RESET;
			suppress_q     <= 1'b0;
			range_count_q  <= 3'd1;
			range_starts_q <= lbfc_pkg::RANGE_W'(1);
			range_ends_q   <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				lbfc_pkg::REG_CUT_MODE:     cut_mode_q     <= pwdata[0];
				lbfc_pkg::REG_DELIMITER:    delimiter_q    <= pwdata[7:0];
				lbfc_pkg::REG_SUPPRESS:     suppress_q     <= pwdata[0];
				lbfc_pkg::REG_RANGE_COUNT:  range_count_q  <= pwdata[2:0];
				lbfc_pkg::REG_RANGE_STARTS: range_starts_q <= pwdata[63:0];
				lbfc_pkg::REG_RANGE_ENDS:   range_ends_q   <= pwdata[63:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			lbfc_pkg::REG_CUT_MODE:     prdata = DW'(cut_mode_q);
			lbfc_pkg::REG_DELIMITER:    prdata = DW'(delimiter_q);
			lbfc_pkg::REG_SUPPRESS:     prdata = DW'(suppress_q);
			lbfc_pkg::REG_RANGE_COUNT:  prdata = DW'(range_count_q);
			lbfc_pkg::REG_RANGE_STARTS: prdata = range_starts_q;
			lbfc_pkg::REG_RANGE_ENDS:   prdata = range_ends_q;
			default:                    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------- handshake
	// The output register frees up when empty or drained this cycle; an item
	// is taken only in idle so that at most one result goes straight out.
	assign slot_free = !out_valid_q || !dst_stall;
	assign src_stall = !((state_q == S_IDLE) && slot_free);
	assign accept    = src_valid && !src_stall;
	assign dst_valid = out_valid_q;
	assign dst_item  = out_q;

	// Load the output register with a direct result or a released byte
	assign out_load = ((state_q == S_IDLE) && accept && emit_now) ||
		(((state_q == S_FL_EMIT) || (state_q == S_TAIL)) && slot_free);

	// Position saturates at all ones
	assign pos_adv  = (&pos_q) ? pos_q : pos_q + 1'b1;
	assign hcnt_dec = hcnt_q - 1'b1;

	lbfc_range_sel #(
		.MAX_RANGES    (MAX_RANGES),
		.POSITION_BITS (POSITION_BITS)
	) u_range_sel (
		.range_count  (range_count_q),
		.range_starts (range_starts_q),
		.range_ends   (range_ends_q),
		.pos_cur      (pos_q),
		.pos_next     (pos_adv),
		.sel          (sel)
	);

	// ----------------------------------------------------------- step decode
	always_comb begin
		logic [7:0] b;
		logic       held_any;
		logic       tail_want;
		b           = src_item.data_byte;
		held_any    = (hcnt_q != '0);
		tail_want   = sel.hit_next && sel.next_above_min;
		emit_now    = 1'b0;
		emit_byte   = b;
		start_flush = 1'b0;
		tail_flag   = 1'b0;
		tail_byte   = lbfc_pkg::NEWLINE;
		clr_line    = 1'b0;
		adv         = 1'b0;
		set_dseen   = 1'b0;
		clr_hcnt    = 1'b0;
		mem_we      = 1'b0;
		set_ovf     = 1'b0;
		priority if (src_item.end_of_stream) begin
			// finish the line without a newline; release an undelimited field
			clr_line    = 1'b1;
			start_flush = cut_mode_q && !dseen_q && !suppress_q && held_any;
		end else if (b == lbfc_pkg::NEWLINE) begin
			clr_line = 1'b1;
			if (!cut_mode_q || dseen_q) begin
				emit_now  = 1'b1;
				emit_byte = lbfc_pkg::NEWLINE;
			end else if (!suppress_q) begin
				if (held_any) begin
					start_flush = 1'b1;
					tail_flag   = 1'b1;
				end else begin
					emit_now  = 1'b1;
					emit_byte = lbfc_pkg::NEWLINE;
				end
			end
		end else if (!cut_mode_q) begin
			adv      = 1'b1;
			emit_now = sel.hit_cur;
		end else if (b == delimiter_q) begin
			adv       = 1'b1;
			tail_byte = delimiter_q;
			if (!dseen_q) begin
				set_dseen = 1'b1;
				clr_hcnt  = 1'b1;
			end
			if (!dseen_q && sel.hit_cur && held_any) begin
				start_flush = 1'b1;
				tail_flag   = tail_want;
			end else if (tail_want) begin
				emit_now  = 1'b1;
				emit_byte = delimiter_q;
			end
		end else if (!dseen_q) begin
			// park first-field bytes; drop and mark once the store is full
			if (hcnt_q < CNT_W'(HOLD_DEPTH)) begin
				mem_we = accept;
			end else begin
				set_ovf = 1'b1;
			end
		end else begin
			emit_now = sel.hit_cur;
		end
	end

	// ------------------------------------------------------------ hold store
	assign mem_re = (state_q == S_FL_RD);

	lbfc_hold_mem #(
		.DEPTH (HOLD_DEPTH),
		.IDX_W (IDX_W)
	) u_hold_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (hcnt_q[IDX_W-1:0]),
		.wdata (src_item.data_byte),
		.re    (mem_re),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	// ------------------------------------------------------------ line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POSITION_BITS'(1);
			dseen_q <= 1'b0;
			hcnt_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (clr_line) begin
				pos_q   <= POSITION_BITS'(1);
				dseen_q <= 1'b0;
				hcnt_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (adv) begin
					pos_q <= pos_adv;
				end
				if (set_dseen) begin
					dseen_q <= 1'b1;
				end
				if (clr_hcnt) begin
					hcnt_q <= '0;
				end else if (mem_we) begin
					hcnt_q <= hcnt_q + 1'b1;
				end
				if (set_ovf) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------- sequencer
	// Idle takes items and sends single results; a release walks the hold
	// store read by read, then sends any trailing newline or delimiter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			idx_q        <= '0;
			flush_last_q <= '0;
			tail_q       <= 1'b0;
			tail_byte_q  <= lbfc_pkg::NEWLINE;
			flush_ovf_q  <= 1'b0;
		end else begin
			// raise valid on a new result, drop it once the item is drained
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (dst_valid && !dst_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && start_flush) begin
						idx_q        <= '0;
						flush_last_q <= hcnt_dec[IDX_W-1:0];
						tail_q       <= tail_flag;
						tail_byte_q  <= tail_byte;
						flush_ovf_q  <= ovf_q;
						state_q      <= S_FL_RD;
					end else if (accept && emit_now) begin
						out_q.out_byte    <= emit_byte;
						out_q.held_overflow <= ovf_q;
						out_q.last_of_run <= 1'b1;
					end
				end
				S_FL_RD: begin
					state_q <= S_FL_EMIT;
				end
				S_FL_EMIT: begin
					if (slot_free) begin
						out_q.out_byte      <= mem_rdata;
						out_q.held_overflow <= flush_ovf_q;
						out_q.last_of_run   <= (idx_q == flush_last_q) && !tail_q;
						if (idx_q == flush_last_q) begin
							state_q <= tail_q ? S_TAIL : S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_FL_RD;
						end
					end
				end
				S_TAIL: begin
					if (slot_free) begin
						out_q.out_byte      <= tail_byte_q;
						out_q.held_overflow <= flush_ovf_q;
						out_q.last_of_run   <= 1'b1;
						tail_q              <= 1'b0;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------ assertions
	// The hold store is written only while no release is reading it.
	a_no_write_in_release: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !mem_we)
		else $error("hold store written during a release");

	// The held count never passes the store depth.
	a_hcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q <= CNT_W'(HOLD_DEPTH))
		else $error("held count beyond hold depth");

	// A release never reads beyond the bytes that were held.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FL_EMIT || state_q == S_FL_RD) |-> idx_q <= flush_last_q)
		else $error("release index beyond held bytes");

	// The trailing byte of a release is a newline or the delimiter.
	a_tail_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAIL) |->
			(tail_byte_q == lbfc_pkg::NEWLINE || tail_byte_q == delimiter_q))
		else $error("unexpected trailing byte");

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line byte/field cutter. A short directed table
// walks after-reset behaviour, the byte extremes, empty and oversized range
// sets, field splitting, undelimited and suppressed lines, a newline used as
// delimiter and end of stream. Random phases then send well-formed lines with
// random content and some noise, over random register settings and idling
// patterns. Every item is mirrored in a behavioural cut model; each output
// item is compared field by field with the oldest expected output.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          PHASE_COUNT   = 10;
	localparam int          PHASE_ITEMS   = 36;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          QUIET_LIMIT   = 5000;
	localparam int unsigned POS_MAX       = (1 << lbfc_pkg::POSITION_BITS_DEF) - 1;

	// Directed row kinds: register write, item checked by the model,
	// item with no output, item with one output typed into the row
	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_PREDICT,
		ROW_NONE,
		ROW_ONE
	} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		lbfc_pkg::reg_idx_t  idx;
		logic [63:0]         val;
		lbfc_pkg::lbfc_in_t  item;
		lbfc_pkg::lbfc_out_t want;
	} plan_row_t;

	localparam int PLAN_LEN = 36;

	// Clock, reset and block inputs, all known from time zero
	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            src_valid = 1'b0;
	lbfc_pkg::lbfc_in_t              src_item  = '0;
	logic                            dst_stall = 1'b0;
	logic                            psel      = 1'b0;
	logic                            penable   = 1'b0;
	logic                            pwrite    = 1'b0;
	logic [lbfc_pkg::CFG_ADDR_W-1:0] paddr     = '0;
	logic [lbfc_pkg::CFG_DATA_W-1:0] pwdata    = '0;

	logic                            src_stall;
	logic                            dst_valid;
	lbfc_pkg::lbfc_out_t             dst_item;
	logic [lbfc_pkg::CFG_DATA_W-1:0] prdata;
	logic                            pready;

	// Idling knobs, percent per cycle
	int source_gap_pct = 0;
	int sink_stall_pct = 0;

	// Register mirror
	logic        cfg_field_mode;
	logic [7:0]  cfg_delim;
	logic        cfg_suppress;
	logic [2:0]  cfg_rcount;
	logic [63:0] cfg_starts;
	logic [63:0] cfg_ends;

	// Line state mirror
	int unsigned cur_pos;
	logic        delim_hit;
	logic [7:0]  hold_mem [lbfc_pkg::HOLD_DEPTH_DEF];
	int unsigned hold_cnt;
	logic        hold_ovf;

	lbfc_pkg::lbfc_out_t step_res [$];   // outputs of the item just taken
	lbfc_pkg::lbfc_out_t cut_expect [$]; // outputs still owed by the block
	lbfc_pkg::lbfc_out_t cut_head;
	plan_row_t           plan [0:PLAN_LEN-1];
	int                  fail_count = 0;
	int                  items_fed  = 0;
	int                  quiet_cycles = 0;

	line_byte_field_cutter_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #10 clk = ~clk;

	// Receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		dst_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// ------------------------------------------------------------------
	// Cut model
	// ------------------------------------------------------------------

	// Union of the live range slots; a zero start counts as one, a zero
	// end leaves the range open
	function automatic bit pos_selected(input int unsigned p);
		int unsigned n, lo, hi, k;
		n = (cfg_rcount > lbfc_pkg::MAX_RANGES_DEF) ? lbfc_pkg::MAX_RANGES_DEF : cfg_rcount;
		for (k = 0; k < n; k++) begin
			lo = cfg_starts[k*lbfc_pkg::SLOT_W +: lbfc_pkg::SLOT_W];
			hi = cfg_ends[k*lbfc_pkg::SLOT_W +: lbfc_pkg::SLOT_W];
			if (lo == 0)
				lo = 1;
			if (p >= lo && (hi == 0 || p <= hi))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int unsigned lowest_start();
		int unsigned n, lo, k, m;
		n = (cfg_rcount > lbfc_pkg::MAX_RANGES_DEF) ? lbfc_pkg::MAX_RANGES_DEF : cfg_rcount;
		m = 32'hFFFF_FFFF;
		for (k = 0; k < n; k++) begin
			lo = cfg_starts[k*lbfc_pkg::SLOT_W +: lbfc_pkg::SLOT_W];
			if (lo == 0)
				lo = 1;
			if (lo < m)
				m = lo;
		end
		return m;
	endfunction

	function automatic void push_cut(input logic [7:0] b);
		lbfc_pkg::lbfc_out_t r;
		r.out_byte      = b;
		r.held_overflow = hold_ovf;
		r.last_of_run   = 1'b0;
		step_res.push_back(r);
	endfunction

	function automatic void push_held();
		int unsigned i;
		for (i = 0; i < hold_cnt; i++)
			push_cut(hold_mem[i]);
	endfunction

	function automatic void clear_line();
		cur_pos   = 1;
		delim_hit = 1'b0;
		hold_cnt  = 0;
		hold_ovf  = 1'b0;
	endfunction

	function automatic void bump_pos();
		if (cur_pos < POS_MAX)
			cur_pos++;
	endfunction

	// Work out what one accepted item makes the block emit
	function automatic void cut_predict(input lbfc_pkg::lbfc_in_t it);
		lbfc_pkg::lbfc_out_t r;
		step_res.delete();
		if (it.end_of_stream) begin
			// no newline added; an undecided first field still goes out
			if (cfg_field_mode && !delim_hit && !cfg_suppress)
				push_held();
			clear_line();
		end else if (it.data_byte == lbfc_pkg::NEWLINE) begin
			// newline wins even when it is also the delimiter
			if (!cfg_field_mode || delim_hit) begin
				push_cut(lbfc_pkg::NEWLINE);
			end else if (!cfg_suppress) begin
				push_held();
				push_cut(lbfc_pkg::NEWLINE);
			end
			clear_line();
		end else if (!cfg_field_mode) begin
			if (pos_selected(cur_pos))
				push_cut(it.data_byte);
			bump_pos();
		end else if (it.data_byte == cfg_delim) begin
			if (!delim_hit) begin
				delim_hit = 1'b1;
				if (pos_selected(cur_pos))
					push_held();
				hold_cnt = 0;
			end
			bump_pos();
			if (pos_selected(cur_pos) && cur_pos > lowest_start())
				push_cut(cfg_delim);
		end else if (!delim_hit) begin
			// park the first field; once full, drop and flag
			if (hold_cnt < lbfc_pkg::HOLD_DEPTH_DEF) begin
				hold_mem[hold_cnt] = it.data_byte;
				hold_cnt++;
			end else begin
				hold_ovf = 1'b1;
			end
		end else if (pos_selected(cur_pos)) begin
			push_cut(it.data_byte);
		end
		if (step_res.size() > 0) begin
			r = step_res.pop_back();
			r.last_of_run = 1'b1;
			step_res.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one item, hold it until taken, then book its outputs. Called
	// on a rising edge and returns on the edge that took the item.
	task automatic feed_item(input lbfc_pkg::lbfc_in_t it, input row_kind_t how,
			input lbfc_pkg::lbfc_out_t typed);
		bit taken;
		while ($urandom_range(99) < source_gap_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		do begin
			@(negedge clk);
			taken = !src_stall;
			@(posedge clk);
		end while (!taken);
		cut_predict(it);
		case (how)
			ROW_ONE: cut_expect.push_back(typed);
			ROW_NONE: ;
			default: begin
				foreach (step_res[j])
					cut_expect.push_back(step_res[j]);
			end
		endcase
		items_fed++;
	endtask

	// Drop valid and hold off until every owed output has come, then let
	// the block settle, since an item with no output may still be in flight
	task automatic hold_until_drained();
		src_valid <= 1'b0;
		do @(posedge clk); while (cut_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, access cycle, then the bus is left idle
	task automatic reg_write(input lbfc_pkg::reg_idx_t idx, input logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			lbfc_pkg::REG_CUT_MODE:     cfg_field_mode = val[0];
			lbfc_pkg::REG_DELIMITER:    cfg_delim      = val[7:0];
			lbfc_pkg::REG_SUPPRESS:     cfg_suppress   = val[0];
			lbfc_pkg::REG_RANGE_COUNT:  cfg_rcount     = val[2:0];
			lbfc_pkg::REG_RANGE_STARTS: cfg_starts     = val;
			lbfc_pkg::REG_RANGE_ENDS:   cfg_ends       = val;
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Output checker: an output is taken at the edge after a low-stall,
	// high-valid half cycle, so sample on the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			if (cut_expect.size() == 0) begin
				$error("out_byte: expected nothing, got %02h", dst_item.out_byte);
				fail_count++;
			end else begin
				cut_head = cut_expect.pop_front();
				if (dst_item.out_byte !== cut_head.out_byte) begin
					$error("out_byte: expected %02h, got %02h",
						cut_head.out_byte, dst_item.out_byte);
					fail_count++;
				end
				if (dst_item.held_overflow !== cut_head.held_overflow) begin
					$error("held_overflow: expected %0b, got %0b",
						cut_head.held_overflow, dst_item.held_overflow);
					fail_count++;
				end
				if (dst_item.last_of_run !== cut_head.last_of_run) begin
					$error("last_of_run: expected %0b, got %0b",
						cut_head.last_of_run, dst_item.last_of_run);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves an item
	always @(negedge clk) begin
		if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		lbfc_pkg::lbfc_in_t nxt;
		logic [7:0]  b;
		logic [7:0]  dl;
		logic [15:0] s, e;
		logic [63:0] st, en;
		logic [2:0]  rc;
		bit          fmode, sup;
		int          ph, f, nf, flen, n, roll, k, phase_mark;

		// Mirror the reset values of registers and line state
		cfg_field_mode = 1'b0;
		cfg_delim      = lbfc_pkg::DELIM_RESET;
		cfg_suppress   = 1'b0;
		cfg_rcount     = 3'd1;
		cfg_starts     = 64'd1;
		cfg_ends       = 64'd0;
		clear_line();

		// Directed table. Typed outputs only where obvious; the rest are
		// left to the model.
		plan = '{
			// after reset: byte mode, range 1 to open end
			'{ROW_ONE,     lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'h41, 1'b0},
				lbfc_pkg::lbfc_out_t'{8'h41, 1'b0, 1'b1}},
			'{ROW_ONE,     lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'hFF, 1'b0},
				lbfc_pkg::lbfc_out_t'{8'hFF, 1'b0, 1'b1}},
			'{ROW_ONE,     lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'h00, 1'b0},
				lbfc_pkg::lbfc_out_t'{8'h00, 1'b0, 1'b1}},
			'{ROW_ONE,     lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{lbfc_pkg::NEWLINE, 1'b0},
				lbfc_pkg::lbfc_out_t'{lbfc_pkg::NEWLINE, 1'b0, 1'b1}},
			'{ROW_ONE,     lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'h42, 1'b0},
				lbfc_pkg::lbfc_out_t'{8'h42, 1'b0, 1'b1}},
			// end of stream mid-line in byte mode: nothing, data ignored
			'{ROW_NONE,    lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'hFF, 1'b1}, '0},
			// no ranges at all: only the newline survives
			'{ROW_WRITE,   lbfc_pkg::REG_RANGE_COUNT, 64'd0, '0, '0},
			'{ROW_NONE,    lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'h55, 1'b0}, '0},
			'{ROW_ONE,     lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{lbfc_pkg::NEWLINE, 1'b0},
				lbfc_pkg::lbfc_out_t'{lbfc_pkg::NEWLINE, 1'b0, 1'b1}},
			// count above the slot limit, zero starts, ends below starts
			'{ROW_WRITE,   lbfc_pkg::REG_RANGE_COUNT,  64'd7, '0, '0},
			'{ROW_WRITE,   lbfc_pkg::REG_RANGE_STARTS, 64'h0000_0004_0000_0006, '0, '0},
			'{ROW_WRITE,   lbfc_pkg::REG_RANGE_ENDS,   64'h0001_0002_0001_0000, '0, '0},
			'{ROW_PREDICT, lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'h61, 1'b0}, '0},
			'{ROW_PREDICT, lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'h62, 1'b0}, '0},
			'{ROW_PREDICT, lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{lbfc_pkg::NEWLINE, 1'b0}, '0},
			// field mode, field 2 onwards, tab delimiter
			'{ROW_WRITE,   lbfc_pkg::REG_CUT_MODE,     64'd1, '0, '0},
			'{ROW_WRITE,   lbfc_pkg::REG_RANGE_COUNT,  64'd1, '0, '0},
			'{ROW_WRITE,   lbfc_pkg::REG_RANGE_STARTS, 64'd2, '0, '0},
			'{ROW_WRITE,   lbfc_pkg::REG_RANGE_ENDS,   64'd0, '0, '0},
			'{ROW_NONE,    lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'h61, 1'b0}, '0},
			'{ROW_NONE,    lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{lbfc_pkg::DELIM_RESET, 1'b0}, '0},
			'{ROW_ONE,     lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'h62, 1'b0},
				lbfc_pkg::lbfc_out_t'{8'h62, 1'b0, 1'b1}},
			'{ROW_ONE,     lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{lbfc_pkg::DELIM_RESET, 1'b0},
				lbfc_pkg::lbfc_out_t'{lbfc_pkg::DELIM_RESET, 1'b0, 1'b1}},
			'{ROW_ONE,     lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{lbfc_pkg::NEWLINE, 1'b0},
				lbfc_pkg::lbfc_out_t'{lbfc_pkg::NEWLINE, 1'b0, 1'b1}},
			// undelimited line passes whole
			'{ROW_NONE,    lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'h63, 1'b0}, '0},
			'{ROW_PREDICT, lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{lbfc_pkg::NEWLINE, 1'b0}, '0},
			// ... or vanishes when suppressed
			'{ROW_WRITE,   lbfc_pkg::REG_SUPPRESS, 64'd1, '0, '0},
			'{ROW_NONE,    lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'h64, 1'b0}, '0},
			'{ROW_NONE,    lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{lbfc_pkg::NEWLINE, 1'b0}, '0},
			// newline as delimiter, line cut short by end of stream
			'{ROW_WRITE,   lbfc_pkg::REG_SUPPRESS,  64'd0, '0, '0},
			'{ROW_WRITE,   lbfc_pkg::REG_DELIMITER, 64'h0A, '0, '0},
			'{ROW_NONE,    lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'h65, 1'b0}, '0},
			'{ROW_ONE,     lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'h00, 1'b1},
				lbfc_pkg::lbfc_out_t'{8'h65, 1'b0, 1'b1}},
			// top delimiter value, empty first field
			'{ROW_WRITE,   lbfc_pkg::REG_DELIMITER, 64'hFF, '0, '0},
			'{ROW_NONE,    lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{8'hFF, 1'b0}, '0},
			'{ROW_ONE,     lbfc_pkg::REG_CUT_MODE, 64'd0,
				lbfc_pkg::lbfc_in_t'{lbfc_pkg::NEWLINE, 1'b0},
				lbfc_pkg::lbfc_out_t'{lbfc_pkg::NEWLINE, 1'b0, 1'b1}}
		};

		// Hold reset low, then release it once
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; registers only change with the block idle
		for (k = 0; k < PLAN_LEN; k++) begin
			if (plan[k].kind == ROW_WRITE) begin
				hold_until_drained();
				reg_write(plan[k].idx, plan[k].val);
			end else begin
				feed_item(plan[k].item, plan[k].kind, plan[k].want);
			end
		end

		// Random phases: fresh settings and idling pattern each time
		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			hold_until_drained();
			case (ph % 4)
				0: begin source_gap_pct = 0;  sink_stall_pct = 0;  end
				1: begin source_gap_pct = 87; sink_stall_pct = 0;  end
				2: begin source_gap_pct = 0;  sink_stall_pct = 87; end
				default: begin source_gap_pct = 30; sink_stall_pct = 30; end
			endcase

			fmode = ($urandom_range(9) < 6);
			sup   = $urandom_range(1);
			case ($urandom_range(5))
				0: dl = 8'h00;
				1: dl = 8'hFF;
				2: dl = 8'($urandom_range(255));
				3: dl = lbfc_pkg::NEWLINE;
				default: dl = lbfc_pkg::DELIM_RESET;
			endcase
			rc = ($urandom_range(9) < 7) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(7));
			for (k = 0; k < 4; k++) begin
				case ($urandom_range(9))
					0: s = 16'hFFFF;
					1: s = 16'h0000;
					default: s = 16'($urandom_range(1, 10));
				endcase
				case ($urandom_range(5))
					0, 1: e = 16'h0000;
					2: e = 16'($urandom_range(16'hFFFF));
					3: e = (s > 1) ? s - 16'd1 : 16'd0;
					default: e = s + 16'($urandom_range(3));
				endcase
				st[k*lbfc_pkg::SLOT_W +: lbfc_pkg::SLOT_W] = s;
				en[k*lbfc_pkg::SLOT_W +: lbfc_pkg::SLOT_W] = e;
			end
			// pin the corner settings to fixed phases
			case (ph)
				1: begin fmode = 1'b1; dl = 8'h00; end
				2: rc = 3'd0;
				3: begin fmode = 1'b1; dl = 8'hFF; sup = 1'b1; end
				5: begin fmode = 1'b1; dl = lbfc_pkg::NEWLINE; end
				6: rc = 3'd7;
				7: fmode = 1'b0;
				default: ;
			endcase
			reg_write(lbfc_pkg::REG_CUT_MODE,     64'(fmode));
			reg_write(lbfc_pkg::REG_DELIMITER,    64'(dl));
			reg_write(lbfc_pkg::REG_SUPPRESS,     64'(sup));
			reg_write(lbfc_pkg::REG_RANGE_COUNT,  64'(rc));
			reg_write(lbfc_pkg::REG_RANGE_STARTS, st);
			reg_write(lbfc_pkg::REG_RANGE_ENDS,   en);

			phase_mark = items_fed;
			while (items_fed - phase_mark < PHASE_ITEMS) begin
				roll = $urandom_range(9);
				if (roll == 0) begin
					// noise: any byte, newlines included
					n = $urandom_range(10);
					repeat (n) begin
						nxt = lbfc_pkg::lbfc_in_t'{8'($urandom_range(255)), 1'b0};
						feed_item(nxt, ROW_PREDICT, '0);
					end
				end else if (cfg_field_mode) begin
					// well-formed fields; now and then a long first field that
					// can overrun the hold store
					nf = $urandom_range(1, 6);
					for (f = 0; f < nf; f++) begin
						if (f > 0)
							feed_item(lbfc_pkg::lbfc_in_t'{cfg_delim, 1'b0},
								ROW_PREDICT, '0);
						flen = (f == 0 && $urandom_range(5) == 0) ?
							$urandom_range(58, 70) : $urandom_range(4);
						repeat (flen) begin
							do b = 8'($urandom_range(255));
							while (b == lbfc_pkg::NEWLINE || b == cfg_delim);
							feed_item(lbfc_pkg::lbfc_in_t'{b, 1'b0}, ROW_PREDICT, '0);
						end
					end
				end else begin
					n = ($urandom_range(7) == 0) ? $urandom_range(17, 30) :
						$urandom_range(12);
					repeat (n) begin
						do b = 8'($urandom_range(255)); while (b == lbfc_pkg::NEWLINE);
						feed_item(lbfc_pkg::lbfc_in_t'{b, 1'b0}, ROW_PREDICT, '0);
					end
				end
				// close the line, mostly with a newline
				if ($urandom_range(9) == 0)
					nxt = lbfc_pkg::lbfc_in_t'{8'($urandom_range(255)), 1'b1};
				else
					nxt = lbfc_pkg::lbfc_in_t'{lbfc_pkg::NEWLINE, 1'b0};
				feed_item(nxt, ROW_PREDICT, '0);
				// occasionally let the output side run dry
				if ($urandom_range(15) == 0)
					hold_until_drained();
			end
		end

		// Wait for the last outputs, give stragglers time to show up
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
